// ===== hw/rtl/radix_suffix_number_parser_assert.svh =====
// Assertion macros shared by the radix suffix number parser RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef RADIX_SUFFIX_NUMBER_PARSER_ASSERT_SVH
`define RADIX_SUFFIX_NUMBER_PARSER_ASSERT_SVH

// Checked on every clock edge once reset is released.
`define RSNP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RSNP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/rsnp_pkg.sv =====
// Package for the radix suffix number parser: word types, character codes,
// radix flag positions and queue sizes. No dependencies.
package rsnp_pkg;

  // Accumulator width; result number is the low NUMBER_WIDTH bits.
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned NUMBER_WIDTH = 32;
  localparam int unsigned EXT_WIDTH    =
    (VALUE_WIDTH > NUMBER_WIDTH) ? VALUE_WIDTH : NUMBER_WIDTH;
  localparam int unsigned DEC_WIDTH    = VALUE_WIDTH + 4;
  localparam int unsigned KILO_SHIFT   = 10;

  // Two-entry queues (depth must be a power of two for pointer wrap).
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  // Radix flag bit positions
  localparam int unsigned RDX_HEX = 0;
  localparam int unsigned RDX_OCT = 1;
  localparam int unsigned RDX_BIN = 2;
  localparam int unsigned RDX_DEC = 3;
  localparam int unsigned NUM_RDX = 4;

  localparam logic [4:0] LIMIT_OCT = 5'd8;
  localparam logic [4:0] LIMIT_BIN = 5'd2;
  localparam logic [4:0] LIMIT_DEC = 5'd10;
  localparam logic [7:0] LETTER_BASE = 8'd10;

  // ASCII codes
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_UH = 8'h48;
  localparam logic [7:0] CH_LH = 8'h68;
  localparam logic [7:0] CH_UO = 8'h4F;
  localparam logic [7:0] CH_LO = 8'h6F;
  localparam logic [7:0] CH_UQ = 8'h51;
  localparam logic [7:0] CH_LQ = 8'h71;
  localparam logic [7:0] CH_UB = 8'h42;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_UK = 8'h4B;
  localparam logic [7:0] CH_LK = 8'h6B;

  typedef enum logic [2:0] {
    SFX_NONE,
    SFX_HEX,
    SFX_OCT,
    SFX_BIN,
    SFX_KILO
  } suffix_e;

  typedef logic [PTR_WIDTH-1:0] qptr_t;
  typedef logic [CNT_WIDTH-1:0] qcnt_t;

  // Input word
  typedef struct packed {
    logic [7:0] symbol;
    logic       final_char;
  } in_t;

  // Result word
  typedef struct packed {
    logic [NUMBER_WIDTH-1:0] number;
    logic                    bad_digit;
    logic                    overflowed;
  } res_t;

  // Classified character handed from front to back
  typedef struct packed {
    logic               final_char;
    suffix_e            suffix;
    logic [3:0]         digit;
    logic [NUM_RDX-1:0] ok;
  } cls_t;

endpackage

// ===== hw/rtl/rsnp_front.sv =====
// Front end of the radix suffix number parser: classifies each character
// and holds it in a two-entry queue for the back end. Uses rsnp_pkg.
`include "radix_suffix_number_parser_assert.svh"

module rsnp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  rsnp_pkg::in_t in_word_i,
  output logic          cls_valid_o,
  output rsnp_pkg::cls_t cls_word_o,
  input  logic          cls_pop_i
);

  rsnp_pkg::cls_t  cls_d;
  rsnp_pkg::cls_t  mem_q [rsnp_pkg::QUEUE_DEPTH];
  rsnp_pkg::qptr_t wr_ptr_q, wr_ptr_d;
  rsnp_pkg::qptr_t rd_ptr_q, rd_ptr_d;
  rsnp_pkg::qcnt_t cnt_q, cnt_d;
  logic            dig_valid;
  logic [3:0]      dig_val;
  logic            wr_en;
  logic            rd_en;

  // Digit value of the character in any radix up to sixteen
  always_comb begin
    dig_valid = 1'b1;
    dig_val   = '0;
    if (in_word_i.symbol inside {[rsnp_pkg::CH_0:rsnp_pkg::CH_9]}) begin
      dig_val = 4'(in_word_i.symbol - rsnp_pkg::CH_0);
    end else if (in_word_i.symbol inside {[rsnp_pkg::CH_UA:rsnp_pkg::CH_UF]}) begin
      dig_val = 4'(in_word_i.symbol - rsnp_pkg::CH_UA + rsnp_pkg::LETTER_BASE);
    end else if (in_word_i.symbol inside {[rsnp_pkg::CH_LA:rsnp_pkg::CH_LF]}) begin
      dig_val = 4'(in_word_i.symbol - rsnp_pkg::CH_LA + rsnp_pkg::LETTER_BASE);
    end else begin
      dig_valid = 1'b0;
    end
  end

  // Classified word: per-radix validity and suffix kind
  always_comb begin
    cls_d.final_char = in_word_i.final_char;
    cls_d.digit      = dig_val;
    cls_d.ok[rsnp_pkg::RDX_HEX] = dig_valid;
    cls_d.ok[rsnp_pkg::RDX_OCT] = dig_valid && ({1'b0, dig_val} < rsnp_pkg::LIMIT_OCT);
    cls_d.ok[rsnp_pkg::RDX_BIN] = dig_valid && ({1'b0, dig_val} < rsnp_pkg::LIMIT_BIN);
    cls_d.ok[rsnp_pkg::RDX_DEC] = dig_valid && ({1'b0, dig_val} < rsnp_pkg::LIMIT_DEC);
    case (1'b1)
      in_word_i.symbol inside {rsnp_pkg::CH_UH, rsnp_pkg::CH_LH}:
        cls_d.suffix = rsnp_pkg::SFX_HEX;
      in_word_i.symbol inside {rsnp_pkg::CH_UO, rsnp_pkg::CH_LO,
                               rsnp_pkg::CH_UQ, rsnp_pkg::CH_LQ}:
        cls_d.suffix = rsnp_pkg::SFX_OCT;
      in_word_i.symbol inside {rsnp_pkg::CH_UB, rsnp_pkg::CH_LB}:
        cls_d.suffix = rsnp_pkg::SFX_BIN;
      in_word_i.symbol inside {rsnp_pkg::CH_UK, rsnp_pkg::CH_LK}:
        cls_d.suffix = rsnp_pkg::SFX_KILO;
      default:
        cls_d.suffix = rsnp_pkg::SFX_NONE;
    endcase
  end

  // Queue control
  assign full        = (cnt_q == rsnp_pkg::qcnt_t'(rsnp_pkg::QUEUE_DEPTH));
  assign cls_valid_o = (cnt_q != '0);
  assign wr_en       = push && !full;
  assign rd_en       = cls_pop_i && cls_valid_o;
  assign cls_word_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + rsnp_pkg::qptr_t'(1);
    end
    if (rd_en) begin
      rd_ptr_d = rd_ptr_q + rsnp_pkg::qptr_t'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + rsnp_pkg::qcnt_t'(1);
      2'b01:   cnt_d = cnt_q - rsnp_pkg::qcnt_t'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cls_d;
    end
  end

  `RSNP_ASSERT(a_front_cnt_bound, cnt_q <= rsnp_pkg::qcnt_t'(rsnp_pkg::QUEUE_DEPTH), "front queue count over depth")
  `RSNP_ASSERT(a_front_drain, rd_en && !wr_en |=> cnt_q == $past(cnt_q) - rsnp_pkg::qcnt_t'(1), "front queue count did not drop on read")
  `RSNP_ASSERT(a_front_full_valid, full |-> cls_valid_o, "front queue full but not valid")

endmodule

// ===== hw/rtl/rsnp_back.sv =====
// Back end of the radix suffix number parser: four radix accumulators,
// suffix resolution and a two-entry result queue. Uses rsnp_pkg.
`include "radix_suffix_number_parser_assert.svh"

module rsnp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cls_valid_i,
  input  rsnp_pkg::cls_t cls_word_i,
  output logic           cls_pop_o,
  output logic           empty,
  input  logic           pop,
  output rsnp_pkg::res_t res_word_o
);

  localparam int unsigned W = rsnp_pkg::VALUE_WIDTH;

  logic [W-1:0]                  hex_q, hex_d;
  logic [W-1:0]                  oct_q, oct_d;
  logic [W-1:0]                  bin_q, bin_d;
  logic [W-1:0]                  dec_q, dec_d;
  logic [rsnp_pkg::NUM_RDX-1:0]  ok_q, ok_d;
  logic [rsnp_pkg::NUM_RDX-1:0]  over_q, over_d;

  logic [rsnp_pkg::DEC_WIDTH-1:0] dec_prod;
  logic [W-1:0]                  dec_next;
  logic                          dec_ovf;
  logic                          hex_ovf, oct_ovf, bin_ovf, kilo_ovf;
  logic [W-1:0]                  hex_next, oct_next, bin_next, kilo_val;

  logic                          sel_ok, sel_over;
  logic [W-1:0]                  sel_val;
  logic [rsnp_pkg::EXT_WIDTH-1:0] sel_ext;
  rsnp_pkg::res_t                res_d;

  logic                          fire, fin;
  rsnp_pkg::res_t                rq_mem_q [rsnp_pkg::QUEUE_DEPTH];
  rsnp_pkg::qptr_t               rq_wr_q, rq_wr_d;
  rsnp_pkg::qptr_t               rq_rd_q, rq_rd_d;
  rsnp_pkg::qcnt_t               rq_cnt_q, rq_cnt_d;
  logic                          rq_full, rq_wr_en, rq_rd_en;

  // Per-radix multiply-add; power-of-two radixes are shifts
  assign hex_ovf  = (hex_q[W-1 -: 4] != '0);
  assign hex_next = {hex_q[W-5:0], cls_word_i.digit};
  assign oct_ovf  = (oct_q[W-1 -: 3] != '0);
  assign oct_next = {oct_q[W-4:0], cls_word_i.digit[2:0]};
  assign bin_ovf  = bin_q[W-1];
  assign bin_next = {bin_q[W-2:0], cls_word_i.digit[0]};

  // Decimal: sum*10 + d as (sum<<3) + (sum<<1) + d
  assign dec_prod = (rsnp_pkg::DEC_WIDTH'(dec_q) << 3) + (rsnp_pkg::DEC_WIDTH'(dec_q) << 1)
                  + rsnp_pkg::DEC_WIDTH'(cls_word_i.digit);
  assign dec_next = dec_prod[W-1:0];
  assign dec_ovf  = (dec_prod[rsnp_pkg::DEC_WIDTH-1:W] != '0);

  // Kilo suffix: decimal times 1024
  assign kilo_ovf = (dec_q[W-1 -: rsnp_pkg::KILO_SHIFT] != '0);
  assign kilo_val = dec_q << rsnp_pkg::KILO_SHIFT;

  // Final character picks the radix
  always_comb begin
    sel_ok   = ok_q[rsnp_pkg::RDX_DEC];
    sel_over = over_q[rsnp_pkg::RDX_DEC];
    sel_val  = dec_q;
    case (cls_word_i.suffix)
      rsnp_pkg::SFX_HEX: begin
        sel_ok   = ok_q[rsnp_pkg::RDX_HEX];
        sel_over = over_q[rsnp_pkg::RDX_HEX];
        sel_val  = hex_q;
      end
      rsnp_pkg::SFX_OCT: begin
        sel_ok   = ok_q[rsnp_pkg::RDX_OCT];
        sel_over = over_q[rsnp_pkg::RDX_OCT];
        sel_val  = oct_q;
      end
      rsnp_pkg::SFX_BIN: begin
        sel_ok   = ok_q[rsnp_pkg::RDX_BIN];
        sel_over = over_q[rsnp_pkg::RDX_BIN];
        sel_val  = bin_q;
      end
      rsnp_pkg::SFX_KILO: begin
        sel_over = over_q[rsnp_pkg::RDX_DEC] || kilo_ovf;
        sel_val  = kilo_val;
      end
      default: begin
        // last character is one more decimal digit
        sel_ok   = ok_q[rsnp_pkg::RDX_DEC] && cls_word_i.ok[rsnp_pkg::RDX_DEC];
        sel_over = over_q[rsnp_pkg::RDX_DEC] || dec_ovf;
        sel_val  = dec_next;
      end
    endcase
    sel_ext = rsnp_pkg::EXT_WIDTH'(sel_val);
    res_d.bad_digit  = !sel_ok;
    res_d.overflowed = sel_ok && sel_over;
    res_d.number     = sel_ok ? sel_ext[rsnp_pkg::NUMBER_WIDTH-1:0] : '0;
  end

  // A final character needs room in the result queue
  assign fin       = cls_word_i.final_char;
  assign fire      = cls_valid_i && (!fin || !rq_full);
  assign cls_pop_o = fire;

  // Accumulator update
  always_comb begin
    hex_d  = hex_q;
    oct_d  = oct_q;
    bin_d  = bin_q;
    dec_d  = dec_q;
    ok_d   = ok_q;
    over_d = over_q;
    if (fire) begin
      if (fin) begin
        hex_d  = '0;
        oct_d  = '0;
        bin_d  = '0;
        dec_d  = '0;
        ok_d   = '1;
        over_d = '0;
      end else begin
        if (cls_word_i.ok[rsnp_pkg::RDX_HEX]) begin
          hex_d = hex_next;
          over_d[rsnp_pkg::RDX_HEX] = over_q[rsnp_pkg::RDX_HEX] || hex_ovf;
        end else begin
          ok_d[rsnp_pkg::RDX_HEX] = 1'b0;
        end
        if (cls_word_i.ok[rsnp_pkg::RDX_OCT]) begin
          oct_d = oct_next;
          over_d[rsnp_pkg::RDX_OCT] = over_q[rsnp_pkg::RDX_OCT] || oct_ovf;
        end else begin
          ok_d[rsnp_pkg::RDX_OCT] = 1'b0;
        end
        if (cls_word_i.ok[rsnp_pkg::RDX_BIN]) begin
          bin_d = bin_next;
          over_d[rsnp_pkg::RDX_BIN] = over_q[rsnp_pkg::RDX_BIN] || bin_ovf;
        end else begin
          ok_d[rsnp_pkg::RDX_BIN] = 1'b0;
        end
        if (cls_word_i.ok[rsnp_pkg::RDX_DEC]) begin
          dec_d = dec_next;
          over_d[rsnp_pkg::RDX_DEC] = over_q[rsnp_pkg::RDX_DEC] || dec_ovf;
        end else begin
          ok_d[rsnp_pkg::RDX_DEC] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_q  <= '0;
      oct_q  <= '0;
      bin_q  <= '0;
      dec_q  <= '0;
      ok_q   <= '1;
      over_q <= '0;
    end else begin
      hex_q  <= hex_d;
      oct_q  <= oct_d;
      bin_q  <= bin_d;
      dec_q  <= dec_d;
      ok_q   <= ok_d;
      over_q <= over_d;
    end
  end

  // Result queue control
  assign rq_full    = (rq_cnt_q == rsnp_pkg::qcnt_t'(rsnp_pkg::QUEUE_DEPTH));
  assign empty      = (rq_cnt_q == '0);
  assign rq_wr_en   = fire && fin;
  assign rq_rd_en   = pop && !empty;
  assign res_word_o = rq_mem_q[rq_rd_q];

  always_comb begin
    rq_wr_d  = rq_wr_q;
    rq_rd_d  = rq_rd_q;
    if (rq_wr_en) begin
      rq_wr_d = rq_wr_q + rsnp_pkg::qptr_t'(1);
    end
    if (rq_rd_en) begin
      rq_rd_d = rq_rd_q + rsnp_pkg::qptr_t'(1);
    end
    case ({rq_wr_en, rq_rd_en})
      2'b10:   rq_cnt_d = rq_cnt_q + rsnp_pkg::qcnt_t'(1);
      2'b01:   rq_cnt_d = rq_cnt_q - rsnp_pkg::qcnt_t'(1);
      default: rq_cnt_d = rq_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      rq_wr_q  <= rq_wr_d;
      rq_rd_q  <= rq_rd_d;
      rq_cnt_q <= rq_cnt_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (rq_wr_en) begin
      rq_mem_q[rq_wr_q] <= res_d;
    end
  end

  `RSNP_ASSERT(a_back_token_clear, fire && fin |=> ok_q == '1 && over_q == '0 && dec_q == '0 && hex_q == '0, "state not cleared after token end")
  `RSNP_ASSERT(a_back_bad_zero, !empty && res_word_o.bad_digit |-> res_word_o.number == '0 && !res_word_o.overflowed, "bad digit result carries a value")
  `RSNP_ASSERT(a_back_rq_bound, rq_cnt_q <= rsnp_pkg::qcnt_t'(rsnp_pkg::QUEUE_DEPTH), "result queue count over depth")
  `RSNP_ASSERT_ALWAYS(a_back_reset_empty, !rst_ni |=> empty, "result queue not empty after reset")

endmodule

// ===== hw/rtl/radix_suffix_number_parser.sv =====
// Radix suffix number parser takes one ASCII character of a number token per
// cycle (push/full) and gives one result per token (empty/pop) when the word
// with final_char set arrives; the suffix H, O/Q, B or K picks hex, octal,
// binary or decimal times 1024, anything else is a last decimal digit. A new
// character is accepted every cycle while full is low; the result of a token
// is written into the result queue when the back end takes its final character
// from the front queue, as long as the result queue has room. The front end
// classifies characters into a two-entry queue; the back end updates all four
// accumulators per character in a single update step that sets throughput, and
// stalls only when both queues fill. Uses rsnp_pkg, rsnp_front, rsnp_back.

module radix_suffix_number_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  rsnp_pkg::in_t  in_word_i,
  output logic           empty,
  input  logic           pop,
  output rsnp_pkg::res_t res_word_o
);

  logic           cls_valid;
  logic           cls_pop;
  rsnp_pkg::cls_t cls_word;

  // Character classification and staging
  rsnp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .cls_valid_o (cls_valid),
    .cls_word_o  (cls_word),
    .cls_pop_i   (cls_pop)
  );

  // Accumulation and result queue
  rsnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (cls_valid),
    .cls_word_i  (cls_word),
    .cls_pop_o   (cls_pop),
    .empty       (empty),
    .pop         (pop),
    .res_word_o  (res_word_o)
  );

endmodule
